/* hw/rtl/mch_pkg.sv */
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for the multichannel histogram
// Bin and lane geometry, the word formats and small helper functions.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int BINS         = 256;
  localparam int MAX_CHANNELS = 3;
  localparam int COUNT_BITS   = 32;
  localparam int NUM_FIELDS   = 3;
  localparam int SAMPLE_BITS  = 8;
  localparam int OUT_BITS     = 32;
  localparam int CFG_BITS     = 2;
  localparam int LANES        = (MAX_CHANNELS < NUM_FIELDS) ? MAX_CHANNELS : NUM_FIELDS;
  localparam int BIN_BITS     = (BINS > 1) ? $clog2(BINS) : 1;

  typedef logic [BIN_BITS-1:0]    bin_addr_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [OUT_BITS-1:0]    out_count_t;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    sample_t    sample0;
    sample_t    sample1;
    sample_t    sample2;
    sample_t    bin_index;
  } in_word_t;

  typedef struct packed {
    out_count_t count0;
    out_count_t count1;
    out_count_t count2;
  } out_word_t;

  typedef struct packed {
    logic      rd_en;
    logic      clr;
    bin_addr_t clr_addr;
  } lane_ctl_t;

  function automatic bin_addr_t to_bin_addr(sample_t s);
    logic [BIN_BITS+SAMPLE_BITS-1:0] w;
    w = {{BIN_BITS{1'b0}}, s};
    return w[BIN_BITS-1:0];
  endfunction

  function automatic logic in_bins(sample_t s);
    return (32'(s) < BINS);
  endfunction

  function automatic out_count_t sat_out(count_t v);
    logic [COUNT_BITS+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, v};
    if (w[COUNT_BITS+OUT_BITS-1:OUT_BITS] != '0) begin
      return '1;
    end
    return w[OUT_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/mch_ram.sv */
// ----------------------------------------------------------------------------
// mch_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mch_lane.sv */
// ----------------------------------------------------------------------------
// mch_lane: one channel's bin counter bank
// Counter RAM with a read-modify-write saturating increment and a clear port.
// ----------------------------------------------------------------------------
module mch_lane (
  input  logic               clk,
  input  mch_pkg::lane_ctl_t ctl,
  input  logic               inc,
  input  mch_pkg::bin_addr_t rd_addr,
  output mch_pkg::count_t    rd_data
);
  import mch_pkg::*;

  bin_addr_t wr_addr_r;
  logic      we;
  bin_addr_t waddr;
  count_t    wdata;
  count_t    bumped;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      wr_addr_r <= rd_addr;
    end
  end

  // counter holds at full scale
  assign bumped = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
  assign we     = ctl.clr | inc;
  assign waddr  = ctl.clr ? ctl.clr_addr : wr_addr_r;
  assign wdata  = ctl.clr ? '0 : bumped;

  mch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

/* hw/rtl/mch_merge.sv */
// ----------------------------------------------------------------------------
// mch_merge: result merge stage
// Masks and clamps the lane counts and registers the result word.
// ----------------------------------------------------------------------------
module mch_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         capture,
  input  logic [mch_pkg::LANES-1:0]    lane_en,
  input  mch_pkg::count_t              lane_data [mch_pkg::LANES],
  output logic                         out_valid,
  output mch_pkg::out_word_t           out_word
);
  import mch_pkg::*;

  out_count_t counts [NUM_FIELDS];
  logic       out_valid_r;
  out_word_t  out_word_r;

  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      counts[i] = '0;
    end
    for (int i = 0; i < LANES; i++) begin
      if (lane_en[i]) begin
        counts[i] = sat_out(lane_data[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= capture;
    end
    if (capture) begin
      out_word_r.count0 <= counts[0];
      out_word_r.count1 <= counts[1];
      out_word_r.count2 <= counts[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* hw/rtl/multichannel_histogram.sv */
// ----------------------------------------------------------------------------
// multichannel_histogram: per-channel histogram of 8-bit samples
// One counter RAM lane per channel, a control sequencer and a merge stage.
//
//   port group  | handshake            | word
//   in_         | start / busy         | in_word  (opcode, samples, bin_index)
//   out_        | out_valid strobe     | out_word (count0..count2)
//   cfg_        | cfg_we               | cfg_wdata (channels_in_use)
//
// Accumulate is a RAM read, then write-back of the incremented count;
// read is a RAM read, then the merge register, which strobes out_valid.
// Clear and reset sweep all BINS rows, one per cycle, busy high.
// busy is the only back-pressure; out_valid lasts one cycle and cannot stall.
// ----------------------------------------------------------------------------
module multichannel_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mch_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  mch_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  output mch_pkg::out_word_t                out_word
);
  import mch_pkg::*;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_INC,
    S_RDO
  } state_t;

  state_t                state_r, state_nxt;
  bin_addr_t             clr_cnt_r, clr_cnt_nxt;
  logic [LANES-1:0]      lane_en_r, lane_en_nxt;
  logic [CFG_BITS-1:0]   channels_r;

  logic                  accept;
  logic [CFG_BITS:0]     n_active;
  sample_t               samples [NUM_FIELDS];
  bin_addr_t             rd_addr [LANES];
  count_t                lane_data [LANES];
  lane_ctl_t             ctl;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign samples[0] = in_word.sample0;
  assign samples[1] = in_word.sample1;
  assign samples[2] = in_word.sample2;

  always_comb begin
    n_active = (channels_r == '0) ? (CFG_BITS+1)'(1) : {1'b0, channels_r};
    if (32'(n_active) > LANES) begin
      n_active = (CFG_BITS+1)'(LANES);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rd_addr[i] = (in_word.opcode == OP_READ) ? to_bin_addr(in_word.bin_index)
                                               : to_bin_addr(samples[i]);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    lane_en_nxt = lane_en_r;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + BIN_BITS'(1);
        if (clr_cnt_r == BIN_BITS'(BINS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          for (int i = 0; i < LANES; i++) begin
            lane_en_nxt[i] = (32'(i) < 32'(n_active)) &&
                             ((in_word.opcode == OP_READ) ? in_bins(in_word.bin_index)
                                                          : in_bins(samples[i]));
          end
          unique case (in_word.opcode)
            OP_ACCUM: state_nxt = S_INC;
            OP_READ:  state_nxt = S_RDO;
            OP_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_INC:   state_nxt = S_IDLE;
      S_RDO:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_cnt_r  <= '0;
      lane_en_r  <= '0;
      channels_r <= CFG_BITS'(1);
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      lane_en_r <= lane_en_nxt;
      if (cfg_we) begin
        channels_r <= cfg_wdata;
      end
    end
  end

  assign ctl.rd_en    = accept;
  assign ctl.clr      = (state_r == S_CLR);
  assign ctl.clr_addr = clr_cnt_r;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mch_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .inc     ((state_r == S_INC) && lane_en_r[g]),
      .rd_addr (rd_addr[g]),
      .rd_data (lane_data[g])
    );
  end

  mch_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .capture   (state_r == S_RDO),
    .lane_en   (lane_en_r),
    .lane_data (lane_data),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

/* tb/multichannel_histogram_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_histogram_checker: bin-count predictor and read-word scoreboard
// Mirrors the per-channel counter store and the channel setting from the
// accepted input and config traffic, queues the counts each read should
// return and compares every strobed result word field by field.
// ----------------------------------------------------------------------------
module multichannel_histogram_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mch_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                         start,
  input  logic                         busy,
  input  mch_pkg::in_word_t            in_word,
  input  logic                         out_valid,
  input  mch_pkg::out_word_t           out_word,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import mch_pkg::*;

  count_t              hist [BINS][MAX_CHANNELS];
  logic [CFG_BITS-1:0] channels_reg;
  out_word_t           expected_reads[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= 100) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  function automatic int active_lanes();
    int n;
    n = (channels_reg == 0) ? 1 : int'(channels_reg);
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    if (n > 3) n = 3;
    return n;
  endfunction

  function automatic out_count_t clip_count(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? '1 : w[31:0];
  endfunction

  task automatic clear_bins();
    foreach (hist[b, c]) hist[b][c] = '0;
  endtask

  task automatic apply_word(in_word_t w);
    int        lanes;
    sample_t   s;
    out_count_t v;
    out_word_t res;
    lanes = active_lanes();
    case (w.opcode)
      OP_ACCUM: begin
        for (int ch = 0; ch < lanes; ch++) begin
          s = (ch == 0) ? w.sample0 : (ch == 1) ? w.sample1 : w.sample2;
          if (32'(s) < BINS && hist[s][ch] != '1) begin
            hist[s][ch] = hist[s][ch] + count_t'(1);
          end
        end
      end
      OP_READ: begin
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
          v = '0;
          if (ch < lanes && 32'(w.bin_index) < BINS) v = clip_count(hist[w.bin_index][ch]);
          case (ch)
            0: res.count0 = v;
            1: res.count1 = v;
            default: res.count2 = v;
          endcase
        end
        expected_reads.push_back(res);
      end
      OP_CLEAR: clear_bins();
      default: ;
    endcase
  endtask

  task automatic compare_read(out_word_t got);
    out_word_t want;
    if (expected_reads.size() == 0) begin
      report($sformatf("read word with none expected: %0d %0d %0d",
                       got.count0, got.count1, got.count2));
      return;
    end
    want = expected_reads.pop_front();
    checked++;
    if (got.count0 !== want.count0)
      report($sformatf("count0 got %0d expected %0d", got.count0, want.count0));
    if (got.count1 !== want.count1)
      report($sformatf("count1 got %0d expected %0d", got.count1, want.count1));
    if (got.count2 !== want.count2)
      report($sformatf("count2 got %0d expected %0d", got.count2, want.count2));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_bins();
      channels_reg = 2'd1;
      expected_reads.delete();
    end else begin
      if (out_valid) compare_read(out_word);
      if (cfg_we) channels_reg = cfg_wdata;
      if (start && !busy) apply_word(in_word);
    end
    pending <= expected_reads.size();
  end

endmodule

/* tb/multichannel_histogram_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_histogram_tb: stimulus and verdict for the histogram block
// Directed words of all opcodes over bin and sample extremes, then random
// traffic in phases over all channel settings, gapped except in phase 4.
// ----------------------------------------------------------------------------
module multichannel_histogram_tb;
  import mch_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         PHASE_WORDS  = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  logic                start;
  logic                busy;
  in_word_t            in_word;
  logic                out_valid;
  out_word_t           out_word;

  int errors, pending, checked;
  int n_accum, n_read, n_clear, n_unused;
  sample_t focus;
  logic [1:0] phase_channels [8] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};

  always #4 clk = ~clk;

  multichannel_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  multichannel_histogram_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_word_t mk(logic [1:0] op, sample_t s0, sample_t s1, sample_t s2,
                                  sample_t b);
    in_word_t w;
    w.opcode    = op;
    w.sample0   = s0;
    w.sample1   = s1;
    w.sample2   = s2;
    w.bin_index = b;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w = mk(OP_ACCUM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 1)) begin
      w.sample0   = focus + 8'($urandom_range(0, 3));
      w.sample1   = focus + 8'($urandom_range(0, 3));
      w.sample2   = focus + 8'($urandom_range(0, 3));
      w.bin_index = focus + 8'($urandom_range(0, 3));
    end
    if (r < 55)      w.opcode = OP_ACCUM;
    else if (r < 93) w.opcode = OP_READ;
    else if (r < 95) w.opcode = OP_CLEAR;
    else             w.opcode = OP_UNUSED;
    return w;
  endfunction

  task automatic send(in_word_t w, bit gaps);
    int idle;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    case (w.opcode)
      OP_ACCUM: n_accum++;
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
    if (gaps && $urandom_range(0, 99) < 37) begin
      idle = $urandom_range(1, 5);
      start   <= 1'b0;
      in_word <= mk(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_channels(logic [1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    start     = 1'b0;
    in_word   = '0;
    focus     = '0;
    n_accum   = 0;
    n_read    = 0;
    n_clear   = 0;
    n_unused  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset value: one channel
    send(mk(OP_ACCUM, 8'd9, 8'd9, 8'd9, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd9), 1'b0);

    write_channels(2'd3);
    send(mk(OP_ACCUM, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_ACCUM, 8'd255, 8'd255, 8'd255, 8'd0), 1'b0);
    send(mk(OP_ACCUM, 8'd0, 8'd255, 8'd128, 8'd0), 1'b0);
    send(mk(OP_ACCUM, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd128), 1'b0);
    send(mk(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_ACCUM, 8'h55, 8'haa, 8'h55, 8'haa), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'h55), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'haa), 1'b0);
    send(mk(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
    send(mk(OP_ACCUM, 8'd1, 8'd2, 8'd3, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd1), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd2), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd3), 1'b0);

    // zero channels acts as one
    write_channels(2'd0);
    send(mk(OP_ACCUM, 8'd7, 8'd7, 8'd7, 8'd0), 1'b0);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd7), 1'b0);
    write_channels(2'd2);
    send(mk(OP_READ, 8'd0, 8'd0, 8'd0, 8'd7), 1'b0);

    for (int p = 0; p < 8; p++) begin
      write_channels(phase_channels[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 25 == 0) focus = 8'($urandom);
        if (p == 2 && i == PHASE_WORDS / 2) drain();
        send(rand_word(), p != 4);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d accumulates, %0d reads, %0d clears, %0d unused opcodes",
             n_accum, n_read, n_clear, n_unused);
    $display("Channel settings 0 to 3 exercised; %0d read words checked", checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mch_pkg.sv
hw/rtl/mch_ram.sv
hw/rtl/mch_lane.sv
hw/rtl/mch_merge.sv
hw/rtl/multichannel_histogram.sv
tb/multichannel_histogram_checker.sv
tb/multichannel_histogram_tb.sv
